// File: design/tcpe_pkg.sv
// Shared types and constants of the passive TCP connection engine.
`default_nettype none

package tcpe_pkg;

  // Action codes of an input item.
  localparam logic [1:0] ACT_SEGMENT = 2'd0;
  localparam logic [1:0] ACT_SEND    = 2'd1;
  localparam logic [1:0] ACT_CLOSE   = 2'd2;

  // TCP flag bits.
  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_RST = 8'h04;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  // Result kinds.
  localparam logic KIND_XMIT    = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PORT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SEQ = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 4'd3;

  localparam logic [31:0] INITIAL_SEQ_RST = 32'h0000_1000;
  localparam logic [15:0] WINDOW_RST      = 16'd8192;
  localparam logic [15:0] HDR_BYTES       = 16'd20;

  // Most results one input item can cause.
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    ST_CLOSED  = 2'd0,
    ST_LISTEN  = 2'd1,
    ST_SYNRCVD = 2'd2,
    ST_ESTAB   = 2'd3
  } conn_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] peer_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flags;
    logic [3:0]  header_words;
    logic [15:0] length;
  } in_item_t;

  typedef struct packed {
    conn_state_t st;
    logic [31:0] peer_addr;
    logic [15:0] remote_port;
    logic [31:0] snd_nxt;
    logic [31:0] rcv_nxt;
  } conn_ctx_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [31:0] initial_seq;
    logic [15:0] window;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] dest_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [15:0] window;
    logic [15:0] data_length;
    logic [5:0]  payload_offset;
  } res_t;

  typedef struct packed {
    logic [1:0]           cnt;
    res_t [MAX_RES-1:0]   slot;
  } res_grp_t;

endpackage

`default_nettype wire

// File: design/tcpe_ifs.sv
// Valid/ready channel interfaces of the passive TCP connection engine.
`default_nettype none

interface tcpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] peer_addr;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [31:0] seq_num;
  logic [31:0] ack_num;
  logic [7:0]  flags;
  logic [3:0]  header_words;
  logic [15:0] length;

  modport source (
    output valid, action, peer_addr, sport, dport, seq_num, ack_num, flags,
           header_words, length,
    input  ready
  );
  modport sink (
    input  valid, action, peer_addr, sport, dport, seq_num, ack_num, flags,
           header_words, length,
    output ready
  );
endinterface

interface tcpe_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] dest_addr;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic [7:0]  out_flags;
  logic [15:0] out_window;
  logic [15:0] data_length;
  logic [5:0]  payload_offset;
  logic        last;

  modport source (
    output valid, kind, dest_addr, out_src_port, out_dst_port, out_seq, out_ack,
           out_flags, out_window, data_length, payload_offset, last,
    input  ready
  );
  modport sink (
    input  valid, kind, dest_addr, out_src_port, out_dst_port, out_seq, out_ack,
           out_flags, out_window, data_length, payload_offset, last,
    output ready
  );
endinterface

interface tcpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/tcpe_seg_logic.sv
// Combinational connection logic: one item and the current state in, results and next state out.
`default_nettype none

module tcpe_seg_logic
  import tcpe_pkg::*;
#(
  parameter int unsigned MAX_SEGMENT = 1600
) (
  input  in_item_t  item,
  input  conn_ctx_t ctx,
  input  cfg_t      cfg,
  output res_grp_t  grp,
  output conn_ctx_t ctx_nxt
);

  localparam logic [16:0] MAX_SEG_W = 17'(MAX_SEGMENT);

  function automatic res_t mk_hdr(input logic [31:0] addr, input logic [15:0] sport,
                                  input logic [15:0] dport, input logic [31:0] seq,
                                  input logic [31:0] ack, input logic [7:0] fl,
                                  input logic [15:0] win, input logic [15:0] dlen);
    res_t r;
    r.kind           = KIND_XMIT;
    r.dest_addr      = addr;
    r.sport          = sport;
    r.dport          = dport;
    r.seq            = seq;
    r.ack            = ack;
    r.flags          = fl;
    r.window         = win;
    r.data_length    = dlen;
    r.payload_offset = '0;
    return r;
  endfunction

  function automatic res_t mk_dlv(input logic [15:0] plen, input logic [5:0] off);
    res_t r;
    r                = '0;
    r.kind           = KIND_DELIVER;
    r.data_length    = plen;
    r.payload_offset = off;
    return r;
  endfunction

  logic [5:0]  off;
  logic [15:0] plen;
  logic        seg_ok;
  logic        has_data;
  logic        fin_ok;
  logic [31:0] rcv_dlv;
  logic [31:0] rcv_pre_fin;
  logic [31:0] rcv_fin;
  logic [31:0] isn_p1;
  logic        send_fits;

  always_comb begin
    off         = {item.header_words, 2'b00};
    plen        = item.length - {10'd0, off};
    seg_ok      = (item.length >= HDR_BYTES) && (ctx.st != ST_CLOSED) &&
                  (item.dport == cfg.local_port) && ({10'd0, off} >= HDR_BYTES) &&
                  ({10'd0, off} <= item.length);
    has_data    = (plen != 16'd0) && (item.seq_num == ctx.rcv_nxt);
    rcv_dlv     = ctx.rcv_nxt + {16'd0, plen};
    // With in-order data the FIN always lines up; otherwise check the raw segment end.
    fin_ok      = ((item.flags & FL_FIN) != 8'd0) &&
                  (has_data || ((item.seq_num + {16'd0, plen}) == ctx.rcv_nxt));
    rcv_pre_fin = has_data ? rcv_dlv : ctx.rcv_nxt;
    rcv_fin     = rcv_pre_fin + 32'd1;
    isn_p1      = cfg.initial_seq + 32'd1;
    send_fits   = ({1'b0, item.length} + {1'b0, HDR_BYTES}) <= MAX_SEG_W;
  end

  always_comb begin
    ctx_nxt = ctx;
    grp     = '0;
    unique case (item.action)
      ACT_SEGMENT: begin
        if (seg_ok) begin
          if ((item.flags & FL_RST) != 8'd0) begin
            ctx_nxt.st = ST_LISTEN;
          end else begin
            unique case (ctx.st)
              ST_LISTEN: begin
                if ((item.flags & FL_SYN) != 8'd0) begin
                  ctx_nxt.peer_addr   = item.peer_addr;
                  ctx_nxt.remote_port = item.sport;
                  ctx_nxt.rcv_nxt     = item.seq_num + 32'd1;
                  ctx_nxt.snd_nxt     = isn_p1;
                  ctx_nxt.st          = ST_SYNRCVD;
                  grp.slot[0] = mk_hdr(item.peer_addr, cfg.local_port, item.sport,
                                       cfg.initial_seq, item.seq_num + 32'd1,
                                       FL_SYN | FL_ACK, cfg.window, 16'd0);
                  grp.cnt     = 2'd1;
                end
              end
              ST_SYNRCVD: begin
                if (((item.flags & FL_ACK) != 8'd0) && (item.ack_num == ctx.snd_nxt)) begin
                  ctx_nxt.st = ST_ESTAB;
                  if (has_data) begin
                    ctx_nxt.rcv_nxt = rcv_dlv;
                    grp.slot[0] = mk_hdr(ctx.peer_addr, cfg.local_port, ctx.remote_port,
                                         ctx.snd_nxt, rcv_dlv, FL_ACK, cfg.window, 16'd0);
                    grp.slot[1] = mk_dlv(plen, off);
                    grp.cnt     = 2'd2;
                  end
                end
              end
              ST_ESTAB: begin
                if (has_data) begin
                  ctx_nxt.rcv_nxt = rcv_dlv;
                  grp.slot[0] = mk_hdr(ctx.peer_addr, cfg.local_port, ctx.remote_port,
                                       ctx.snd_nxt, rcv_dlv, FL_ACK, cfg.window, 16'd0);
                  grp.slot[1] = mk_dlv(plen, off);
                  grp.cnt     = 2'd2;
                end
                if (fin_ok) begin
                  ctx_nxt.rcv_nxt = rcv_fin;
                  ctx_nxt.snd_nxt = ctx.snd_nxt + 32'd1;
                  ctx_nxt.st      = ST_LISTEN;
                  if (has_data) begin
                    grp.slot[2] = mk_hdr(ctx.peer_addr, cfg.local_port, ctx.remote_port,
                                         ctx.snd_nxt, rcv_fin, FL_FIN | FL_ACK, cfg.window,
                                         16'd0);
                    grp.cnt     = 2'd3;
                  end else begin
                    grp.slot[0] = mk_hdr(ctx.peer_addr, cfg.local_port, ctx.remote_port,
                                         ctx.snd_nxt, rcv_fin, FL_FIN | FL_ACK, cfg.window,
                                         16'd0);
                    grp.cnt     = 2'd1;
                  end
                end
              end
              ST_CLOSED: begin
              end
            endcase
          end
        end
      end
      ACT_SEND: begin
        if (ctx.st == ST_ESTAB) begin
          ctx_nxt.snd_nxt = ctx.snd_nxt + {16'd0, item.length};
          if (send_fits) begin
            grp.slot[0] = mk_hdr(ctx.peer_addr, cfg.local_port, ctx.remote_port, ctx.snd_nxt,
                                 ctx.rcv_nxt, FL_PSH | FL_ACK, cfg.window, item.length);
            grp.cnt     = 2'd1;
          end
        end
      end
      ACT_CLOSE: begin
        if ((ctx.st == ST_SYNRCVD) || (ctx.st == ST_ESTAB)) begin
          ctx_nxt.snd_nxt = ctx.snd_nxt + 32'd1;
          ctx_nxt.st      = ST_LISTEN;
          grp.slot[0] = mk_hdr(ctx.peer_addr, cfg.local_port, ctx.remote_port, ctx.snd_nxt,
                               ctx.rcv_nxt, FL_FIN | FL_ACK, cfg.window, 16'd0);
          grp.cnt     = 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/tcpe_res_buf.sv
// Result register that holds the results of one item and hands them out one per transfer.
`default_nettype none

module tcpe_res_buf
  import tcpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  res_grp_t grp_in,
  output logic     free,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     cur,
  output logic     cur_last
);

  res_grp_t   grp_r;
  logic       valid_r;
  logic [1:0] idx_r;
  logic       pop;

  always_comb begin
    unique case (idx_r)
      2'd1:    cur = grp_r.slot[1];
      2'd2:    cur = grp_r.slot[2];
      default: cur = grp_r.slot[0];
    endcase
  end

  assign cur_last  = (idx_r == 2'(grp_r.cnt - 2'd1));
  assign out_valid = valid_r;
  assign pop       = valid_r && out_ready;
  assign free      = !valid_r || (pop && cur_last);

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (pop && cur_last) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: design/tcp_passive_connection_engine.sv
// Top level of the single-connection passive TCP connection engine.
`default_nettype none

// The engine takes parsed headers of received segments and application send
// and close requests on in_chan, and answers on out_chan with headers of
// segments to transmit and with payload-delivery notices, up to three results
// per input item with last set on the final one. An accepted item is held in
// the input register until it can move on; the connection logic works it out
// in a single pass and commits the connection state while its results are
// loaded into the result register, which offers the first result. The result
// register hands out one result per cycle while out_chan.ready is high. An
// item with no results skips the result register; the next item is taken
// in the same cycle that the last result of the
// previous one leaves. Configuration writes on cfg_chan are always ready and
// take effect on the next cycle; they are meant to be issued only while the
// engine is idle. Writing enable moves the engine to listen (1) or closed (0)
// from any state. MAX_SEGMENT bounds the header plus payload of a send; a
// larger send advances the send sequence number but transmits nothing.

module tcp_passive_connection_engine
  import tcpe_pkg::*;
#(
  parameter int unsigned MAX_SEGMENT = 1600
) (
  input  wire             clk,
  input  wire             rst_n,
  tcpe_in_if.sink         in_chan,
  tcpe_out_if.source      out_chan,
  tcpe_cfg_if.sink        cfg_chan
);

  // Input register.
  in_item_t  item_r;
  logic      item_valid_r;

  // Connection state and configuration registers.
  conn_ctx_t ctx_r;
  cfg_t      cfg_r;

  conn_ctx_t ctx_nxt;
  res_grp_t  grp;
  logic      buf_free;
  logic      consume;
  logic      load;
  logic      cfg_wr;
  res_t      cur;
  logic      cur_last;

  // An item with no result leaves the input register at once; one with
  // results waits until the result register can take the whole group.
  assign consume = item_valid_r && ((grp.cnt == 2'd0) || buf_free);
  assign load    = item_valid_r && (grp.cnt != 2'd0) && buf_free;

  assign in_chan.ready  = !item_valid_r || consume;
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid;

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.action       <= in_chan.action;
      item_r.peer_addr    <= in_chan.peer_addr;
      item_r.sport        <= in_chan.sport;
      item_r.dport        <= in_chan.dport;
      item_r.seq_num      <= in_chan.seq_num;
      item_r.ack_num      <= in_chan.ack_num;
      item_r.flags        <= in_chan.flags;
      item_r.header_words <= in_chan.header_words;
      item_r.length       <= in_chan.length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      item_valid_r <= 1'b1;
    end else if (consume) begin
      item_valid_r <= 1'b0;
    end
  end

  // Connection state: a configuration write to enable overrides the state,
  // otherwise the state follows each item as it is worked out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.st          <= ST_CLOSED;
      ctx_r.peer_addr   <= '0;
      ctx_r.remote_port <= '0;
      ctx_r.snd_nxt     <= '0;
      ctx_r.rcv_nxt     <= '0;
    end else if (cfg_wr && (cfg_chan.index == REG_ENABLE)) begin
      ctx_r.st <= cfg_chan.data[0] ? ST_LISTEN : ST_CLOSED;
    end else if (consume) begin
      ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_port  <= '0;
      cfg_r.initial_seq <= INITIAL_SEQ_RST;
      cfg_r.window      <= WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_chan.index)
        REG_LOCAL_PORT:  cfg_r.local_port  <= cfg_chan.data[15:0];
        REG_INITIAL_SEQ: cfg_r.initial_seq <= cfg_chan.data;
        REG_WINDOW:      cfg_r.window      <= cfg_chan.data[15:0];
        default: begin
        end
      endcase
    end
  end

  tcpe_seg_logic #(
    .MAX_SEGMENT(MAX_SEGMENT)
  ) u_seg_logic (
    .item    (item_r),
    .ctx     (ctx_r),
    .cfg     (cfg_r),
    .grp     (grp),
    .ctx_nxt (ctx_nxt)
  );

  tcpe_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp_in    (grp),
    .free      (buf_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cur       (cur),
    .cur_last  (cur_last)
  );

  assign out_chan.kind           = cur.kind;
  assign out_chan.dest_addr      = cur.dest_addr;
  assign out_chan.out_src_port   = cur.sport;
  assign out_chan.out_dst_port   = cur.dport;
  assign out_chan.out_seq        = cur.seq;
  assign out_chan.out_ack        = cur.ack;
  assign out_chan.out_flags      = cur.flags;
  assign out_chan.out_window     = cur.window;
  assign out_chan.data_length    = cur.data_length;
  assign out_chan.payload_offset = cur.payload_offset;
  assign out_chan.last           = cur_last;

endmodule

`default_nettype wire
